// ===== sv/cslc_pkg.sv =====
package cslc_pkg;

    // Input operation codes
    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_SEND    = 3'd1;
    localparam logic [2:0] OP_RECEIVE = 3'd2;
    localparam logic [2:0] OP_FRAME   = 3'd3;
    localparam logic [2:0] OP_CARRIER = 3'd4;

    // Result command codes
    localparam logic [2:0] CMD_LISTEN  = 3'd0;
    localparam logic [2:0] CMD_TEST    = 3'd1;
    localparam logic [2:0] CMD_TX_DATA = 3'd2;
    localparam logic [2:0] CMD_TX_ACK  = 3'd3;
    localparam logic [2:0] CMD_FLUSH   = 3'd4;
    localparam logic [2:0] CMD_OK      = 3'd5;
    localparam logic [2:0] CMD_FAIL    = 3'd6;

    localparam logic [5:0] ACK_FRAME_LEN = 6'd3;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] REG_OWN_ADDRESS   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SEND_TIMEOUT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ACK_TIMEOUT   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ACK_CODE      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_LISTEN_TICKS  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_BACKOFF_TICKS = 3'd5;

    // Configuration reset values
    localparam logic [7:0]  RST_OWN_ADDRESS   = 8'd0;
    localparam logic [31:0] RST_SEND_TIMEOUT  = 32'd10000;
    localparam logic [31:0] RST_ACK_TIMEOUT   = 32'd5000;
    localparam logic [7:0]  RST_ACK_CODE      = 8'd6;
    localparam logic [7:0]  RST_LISTEN_TICKS  = 8'd70;
    localparam logic [7:0]  RST_BACKOFF_TICKS = 8'd150;

    // Result queue
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [2:0]  operation;
        logic [7:0]  dest_address;
        logic [7:0]  source_address;
        logic [5:0]  frame_length;
        logic [31:0] receive_timeout;
        logic [7:0]  rx_byte_zero;
        logic [7:0]  rx_byte_one;
        logic [7:0]  rx_byte_two;
        logic        carrier_busy;
    } in_t;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] tx_byte_zero;
        logic [7:0] tx_byte_one;
        logic [7:0] tx_byte_two;
        logic [5:0] tx_length;
        logic [7:0] received_from;
        logic       last;
    } out_t;

    typedef struct packed {
        logic [7:0]  own_address;
        logic [31:0] send_timeout;
        logic [31:0] ack_timeout;
        logic [7:0]  ack_code;
        logic [7:0]  listen_ticks;
        logic [7:0]  backoff_ticks;
    } cfg_t;

endpackage

// ===== sv/cslc_core.sv =====
module cslc_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  cslc_pkg::in_t     item,
    input  cslc_pkg::cfg_t    cfg,
    output logic [1:0]        res_count,
    output cslc_pkg::out_t    res0,
    output cslc_pkg::out_t    res1
);

    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_S_LISTEN  = 4'd1;
    localparam logic [3:0] PH_S_TEST    = 4'd2;
    localparam logic [3:0] PH_S_BACKOFF = 4'd3;
    localparam logic [3:0] PH_ACK_WAIT  = 4'd4;
    localparam logic [3:0] PH_RX_WAIT   = 4'd5;
    localparam logic [3:0] PH_A_LISTEN  = 4'd6;
    localparam logic [3:0] PH_A_TEST    = 4'd7;
    localparam logic [3:0] PH_A_BACKOFF = 4'd8;

    logic [3:0]  phase_reg, phase_next;
    logic [31:0] elapsed_reg, elapsed_next;
    logic [7:0]  delay_reg, delay_next;
    logic [7:0]  peer_reg, peer_next;
    logic [7:0]  self_reg, self_next;
    logic [5:0]  length_reg, length_next;
    logic [31:0] rx_limit_reg, rx_limit_next;

    logic [31:0] elapsed_inc;
    logic [7:0]  delay_inc;
    logic [7:0]  listen_need;
    logic [7:0]  backoff_need;
    logic        listen_done;
    logic        backoff_done;
    logic        ack_match;
    logic [2:0]  final_cmd;

    function automatic cslc_pkg::out_t mk(input logic [2:0] cmd);
        cslc_pkg::out_t r;
        r = '0;
        r.command = cmd;
        return r;
    endfunction

    // Saturating elapsed count and delay count
    assign elapsed_inc  = (phase_reg != PH_IDLE && elapsed_reg != 32'hFFFF_FFFF) ?
                          elapsed_reg + 32'd1 : elapsed_reg;
    assign delay_inc    = (delay_reg != 8'hFF) ? delay_reg + 8'd1 : delay_reg;
    assign listen_need  = (cfg.listen_ticks == 8'd0) ? 8'd1 : cfg.listen_ticks;
    assign backoff_need = (cfg.backoff_ticks == 8'd0) ? 8'd1 : cfg.backoff_ticks;
    assign listen_done  = delay_inc >= listen_need;
    assign backoff_done = delay_inc >= backoff_need;
    assign ack_match    = item.rx_byte_zero == self_reg && item.rx_byte_one == peer_reg &&
                          item.rx_byte_two == cfg.ack_code;

    always_comb begin
        phase_next    = phase_reg;
        elapsed_next  = elapsed_reg;
        delay_next    = delay_reg;
        peer_next     = peer_reg;
        self_next     = self_reg;
        length_next   = length_reg;
        rx_limit_next = rx_limit_reg;
        res_count     = 2'd0;
        res0          = '0;
        res1          = '0;

        case (item.operation)
            cslc_pkg::OP_TICK: begin
                elapsed_next = elapsed_inc;
                case (phase_reg)
                    PH_S_LISTEN, PH_A_LISTEN: begin
                        delay_next = delay_inc;
                        if (listen_done) begin
                            phase_next = (phase_reg == PH_S_LISTEN) ? PH_S_TEST : PH_A_TEST;
                            res0       = mk(cslc_pkg::CMD_TEST);
                            res_count  = 2'd1;
                        end
                    end
                    PH_S_BACKOFF, PH_A_BACKOFF: begin
                        delay_next = delay_inc;
                        if (backoff_done) begin
                            res_count = 2'd1;
                            if (elapsed_inc < ((phase_reg == PH_S_BACKOFF) ?
                                               cfg.send_timeout : cfg.ack_timeout)) begin
                                delay_next = 8'd0;
                                phase_next = (phase_reg == PH_S_BACKOFF) ?
                                             PH_S_LISTEN : PH_A_LISTEN;
                                res0       = mk(cslc_pkg::CMD_LISTEN);
                            end else begin
                                phase_next = PH_IDLE;
                                res0       = mk(cslc_pkg::CMD_FAIL);
                            end
                        end
                    end
                    PH_ACK_WAIT: begin
                        if (elapsed_inc >= cfg.ack_timeout) begin
                            phase_next = PH_IDLE;
                            res0       = mk(cslc_pkg::CMD_FAIL);
                            res_count  = 2'd1;
                        end
                    end
                    PH_RX_WAIT: begin
                        if (elapsed_inc >= rx_limit_reg) begin
                            phase_next = PH_IDLE;
                            res0       = mk(cslc_pkg::CMD_FLUSH);
                            res1       = mk(cslc_pkg::CMD_FAIL);
                            res_count  = 2'd2;
                        end
                    end
                    default: ;
                endcase
            end
            cslc_pkg::OP_SEND: begin
                if (phase_reg == PH_IDLE) begin
                    peer_next    = item.dest_address;
                    self_next    = item.source_address;
                    length_next  = item.frame_length;
                    elapsed_next = 32'd0;
                    res_count    = 2'd1;
                    if (cfg.send_timeout != 32'd0) begin
                        delay_next = 8'd0;
                        phase_next = PH_S_LISTEN;
                        res0       = mk(cslc_pkg::CMD_LISTEN);
                    end else begin
                        res0 = mk(cslc_pkg::CMD_FAIL);
                    end
                end
            end
            cslc_pkg::OP_RECEIVE: begin
                if (phase_reg == PH_IDLE) begin
                    length_next   = item.frame_length;
                    rx_limit_next = item.receive_timeout;
                    elapsed_next  = 32'd0;
                    if (item.receive_timeout == 32'd0) begin
                        res0      = mk(cslc_pkg::CMD_FLUSH);
                        res1      = mk(cslc_pkg::CMD_FAIL);
                        res_count = 2'd2;
                    end else begin
                        phase_next = PH_RX_WAIT;
                        res0       = mk(cslc_pkg::CMD_LISTEN);
                        res_count  = 2'd1;
                    end
                end
            end
            cslc_pkg::OP_FRAME: begin
                if (phase_reg == PH_ACK_WAIT) begin
                    res_count = 2'd1;
                    if (ack_match) begin
                        phase_next = PH_IDLE;
                        res0       = mk(cslc_pkg::CMD_OK);
                    end else begin
                        res0 = mk(cslc_pkg::CMD_FLUSH);
                    end
                end else if (phase_reg == PH_RX_WAIT) begin
                    res0      = mk(cslc_pkg::CMD_FLUSH);
                    res_count = 2'd1;
                    if (item.rx_byte_zero == cfg.own_address) begin
                        peer_next    = item.rx_byte_one;
                        elapsed_next = 32'd0;
                        res_count    = 2'd2;
                        if (cfg.ack_timeout == 32'd0) begin
                            phase_next = PH_IDLE;
                            res1       = mk(cslc_pkg::CMD_FAIL);
                        end else begin
                            delay_next = 8'd0;
                            phase_next = PH_A_LISTEN;
                            res1       = mk(cslc_pkg::CMD_LISTEN);
                        end
                    end
                end
            end
            cslc_pkg::OP_CARRIER: begin
                if (phase_reg == PH_S_TEST) begin
                    if (item.carrier_busy) begin
                        delay_next = 8'd0;
                        phase_next = PH_S_BACKOFF;
                    end else begin
                        res0              = mk(cslc_pkg::CMD_TX_DATA);
                        res0.tx_byte_zero = peer_reg;
                        res0.tx_byte_one  = self_reg;
                        res0.tx_length    = length_reg;
                        elapsed_next      = 32'd0;
                        res_count         = 2'd2;
                        if (cfg.ack_timeout == 32'd0) begin
                            phase_next = PH_IDLE;
                            res1       = mk(cslc_pkg::CMD_FAIL);
                        end else begin
                            phase_next = PH_ACK_WAIT;
                            res1       = mk(cslc_pkg::CMD_LISTEN);
                        end
                    end
                end else if (phase_reg == PH_A_TEST) begin
                    if (item.carrier_busy) begin
                        delay_next = 8'd0;
                        phase_next = PH_A_BACKOFF;
                    end else begin
                        res0               = mk(cslc_pkg::CMD_TX_ACK);
                        res0.tx_byte_zero  = peer_reg;
                        res0.tx_byte_one   = cfg.own_address;
                        res0.tx_byte_two   = cfg.ack_code;
                        res0.tx_length     = cslc_pkg::ACK_FRAME_LEN;
                        res1               = mk(cslc_pkg::CMD_OK);
                        res1.received_from = peer_reg;
                        res_count          = 2'd2;
                        phase_next         = PH_IDLE;
                    end
                end
            end
            default: ;
        endcase

        if (res_count == 2'd1) begin
            res0.last = 1'b1;
        end
        if (res_count == 2'd2) begin
            res1.last = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            elapsed_reg  <= '0;
            delay_reg    <= '0;
            peer_reg     <= '0;
            self_reg     <= '0;
            length_reg   <= '0;
            rx_limit_reg <= '0;
        end else if (fire) begin
            phase_reg    <= phase_next;
            elapsed_reg  <= elapsed_next;
            delay_reg    <= delay_next;
            peer_reg     <= peer_next;
            self_reg     <= self_next;
            length_reg   <= length_next;
            rx_limit_reg <= rx_limit_next;
        end
    end

    assign final_cmd = (res_count == 2'd2) ? res1.command : res0.command;

    a_done_returns_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res_count != 2'd0 &&
        (final_cmd == cslc_pkg::CMD_OK || final_cmd == cslc_pkg::CMD_FAIL)
        |=> phase_reg == PH_IDLE)
        else $error("exchange finished but phase did not return to idle");

    a_idle_only_on_start: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && phase_reg == PH_IDLE && item.operation != cslc_pkg::OP_SEND &&
        item.operation != cslc_pkg::OP_RECEIVE |-> res_count == 2'd0)
        else $error("idle block produced a result without a start request");

    a_delay_cleared_on_listen: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && phase_reg != PH_S_LISTEN && phase_reg != PH_A_LISTEN &&
        (phase_next == PH_S_LISTEN || phase_next == PH_A_LISTEN)
        |=> delay_reg == 8'd0)
        else $error("listen period started with a stale delay count");

endmodule

// ===== sv/cslc_queue.sv =====
module cslc_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [1:0]        push_count,
    input  cslc_pkg::out_t    push_data0,
    input  cslc_pkg::out_t    push_data1,
    input  logic              pop,
    output logic              head_valid,
    output cslc_pkg::out_t    head_data,
    output logic              room_two
);

    cslc_pkg::out_t mem [cslc_pkg::QUEUE_DEPTH];

    logic [cslc_pkg::QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [cslc_pkg::QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [cslc_pkg::QUEUE_CW-1:0] count_reg, count_next;
    logic [cslc_pkg::QUEUE_AW-1:0] wr_ptr_plus1;

    localparam logic [cslc_pkg::QUEUE_CW-1:0] DEPTH_C = cslc_pkg::QUEUE_CW'(cslc_pkg::QUEUE_DEPTH);

    assign wr_ptr_plus1 = wr_ptr_reg + cslc_pkg::QUEUE_AW'(1);
    assign head_valid   = count_reg != '0;
    assign head_data    = mem[rd_ptr_reg];
    assign room_two     = count_reg <= DEPTH_C - cslc_pkg::QUEUE_CW'(2);

    assign wr_ptr_next = wr_ptr_reg + cslc_pkg::QUEUE_AW'(push_count);
    assign rd_ptr_next = rd_ptr_reg + cslc_pkg::QUEUE_AW'(pop);
    assign count_next  = count_reg + cslc_pkg::QUEUE_CW'(push_count) - cslc_pkg::QUEUE_CW'(pop);

    always_ff @(posedge aclk) begin
        if (push_count != 2'd0) begin
            mem[wr_ptr_reg] <= push_data0;
        end
        if (push_count == 2'd2) begin
            mem[wr_ptr_plus1] <= push_data1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cslc_pkg::QUEUE_CW'(push_count) + count_reg <= DEPTH_C)
        else $error("result queue overflow");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("result queue count out of range");

    a_ptrs_agree: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_ptr_reg == rd_ptr_reg + count_reg[cslc_pkg::QUEUE_AW-1:0])
        else $error("result queue pointers disagree with fill count");

endmodule

// ===== sv/carrier_sense_ack_link_controller_unit.sv =====
// Carrier-sense link controller with stop-and-wait acknowledgement.
// Input channel (s_valid/s_ready/s_data): one word per tick, start request,
// arrived frame header or carrier report. Result channel (m_valid/m_ready/
// m_data): commands to the radio and final status; m_data.last marks the
// final result caused by an input word, and an input word may cause none.
// Configuration (cfg_we/cfg_index/cfg_wdata) writes one register per cycle,
// no wait states; write only while no exchange is in flight.
// A word lands in the input register at its accepting edge, is evaluated
// while held there once the result queue has room for two results, and its
// results are written into the queue, whose head drives m_data.
// Throughput: one input word per cycle when the result queue is not backed up.
// The limit is the four-entry result queue, which must have room for two
// results before a word is evaluated; it hands out results one at a time.
// Reset clears the exchange state to idle, empties the queue and loads the
// register defaults. When the receiver stalls, results collect in the queue;
// once it is nearly full the input register holds and s_ready drops.
module carrier_sense_ack_link_controller_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  cslc_pkg::in_t                       s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output cslc_pkg::out_t                      m_data,
    input  logic                                cfg_we,
    input  logic [cslc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [cslc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    cslc_pkg::cfg_t cfg_reg;
    cslc_pkg::in_t  stg_item_reg;
    logic           stg_valid_reg;
    logic           fire;
    logic           room_two;
    logic [1:0]     res_count;
    logic [1:0]     push_count;
    cslc_pkg::out_t res0;
    cslc_pkg::out_t res1;

    // Configuration registers: take effect at once.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.own_address   <= cslc_pkg::RST_OWN_ADDRESS;
            cfg_reg.send_timeout  <= cslc_pkg::RST_SEND_TIMEOUT;
            cfg_reg.ack_timeout   <= cslc_pkg::RST_ACK_TIMEOUT;
            cfg_reg.ack_code      <= cslc_pkg::RST_ACK_CODE;
            cfg_reg.listen_ticks  <= cslc_pkg::RST_LISTEN_TICKS;
            cfg_reg.backoff_ticks <= cslc_pkg::RST_BACKOFF_TICKS;
        end else if (cfg_we) begin
            case (cfg_index)
                cslc_pkg::REG_OWN_ADDRESS:   cfg_reg.own_address   <= cfg_wdata[7:0];
                cslc_pkg::REG_SEND_TIMEOUT:  cfg_reg.send_timeout  <= cfg_wdata;
                cslc_pkg::REG_ACK_TIMEOUT:   cfg_reg.ack_timeout   <= cfg_wdata;
                cslc_pkg::REG_ACK_CODE:      cfg_reg.ack_code      <= cfg_wdata[7:0];
                cslc_pkg::REG_LISTEN_TICKS:  cfg_reg.listen_ticks  <= cfg_wdata[7:0];
                cslc_pkg::REG_BACKOFF_TICKS: cfg_reg.backoff_ticks <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Evaluate the held word once the queue can take both of its results;
    // refill the input register in the same cycle.
    assign fire    = stg_valid_reg && room_two;
    assign s_ready = !stg_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= 1'b0;
        end else if (s_ready) begin
            stg_valid_reg <= s_valid;
        end
    end

    // Payload: load on accept, no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            stg_item_reg <= s_data;
        end
    end

    cslc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .item      (stg_item_reg),
        .cfg       (cfg_reg),
        .res_count (res_count),
        .res0      (res0),
        .res1      (res1)
    );

    // Drop results of a word that is not being evaluated this cycle.
    assign push_count = fire ? res_count : 2'd0;

    cslc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_count (push_count),
        .push_data0 (res0),
        .push_data1 (res1),
        .pop        (m_valid && m_ready),
        .head_valid (m_valid),
        .head_data  (m_data),
        .room_two   (room_two)
    );

endmodule
